@@ src/msr_pkg.sv @@
// Shared types and constants of the spiral-order matrix reader.
package msr_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int CFG_W       = 7;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic              func;
    logic signed [31:0] elem_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               is_last;
    logic               walk_done;
  } rsp_t;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic done_res;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
  } stat_t;

endpackage

@@ src/msr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module msr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/msr_ctrl.sv @@
// Controller: handshake and sequencing of load and fetch beats.
module msr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_func,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  msr_pkg::stat_t stat,
  output msr_pkg::cmd_t  cmd
);

  msr_pkg::ctrl_state_t state, state_next;
  logic                 rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msr_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid && rsp_stall;
    req_stall      = 1'b0;
    cmd            = '0;
    unique case (state)
      msr_pkg::ST_IDLE: begin
        // a fetch needs the output register free by this edge
        req_stall = req_func && rsp_valid && rsp_stall;
        if (req_valid && !req_stall) begin
          if (!req_func) begin
            cmd.load = 1'b1;
          end else if (stat.walk_end) begin
            cmd.done_res   = 1'b1;
            rsp_valid_next = 1'b1;
          end else begin
            cmd.fetch  = 1'b1;
            state_next = msr_pkg::ST_READ;
          end
        end
      end
      msr_pkg::ST_READ: begin
        req_stall      = 1'b1;
        cmd.capture    = 1'b1;
        rsp_valid_next = 1'b1;
        state_next     = msr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/msr_dp.sv @@
// Datapath: size registers, load position, spiral walk, cell store, output beat.
module msr_dp #(
  parameter int MAX_DIM = msr_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic                        cfg_sel,
  input  logic [msr_pkg::DATA_W-1:0]  cfg_wdata,
  output logic [msr_pkg::DATA_W-1:0]  cfg_rdata,
  input  logic signed [31:0]          elem_value,
  input  msr_pkg::cmd_t               cmd,
  output msr_pkg::stat_t              stat,
  output msr_pkg::rsp_t               rsp
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = 2 * DIM_W;
  localparam int ADDR_W = 2 * IDX_W;

  logic [msr_pkg::CFG_W-1:0] num_rows, num_cols;
  logic [msr_pkg::CFG_W-1:0] rows_new, cols_new;
  logic [DIM_W-1:0]          rows_eff, cols_eff;
  logic [CNT_W-1:0]          total;

  logic [CNT_W-1:0] load_count, emitted_count, emitted_inc;
  logic [IDX_W-1:0] load_row, load_col, base_row, base_col;
  logic [IDX_W-1:0] load_row_next, load_col_next;
  logic             load_restart, fetch_last;

  logic [IDX_W-1:0] cur_row, cur_col, bound_top, bound_bottom, bound_left, bound_right;
  logic [IDX_W-1:0] row_next, col_next, top_next, bottom_next, left_next, right_next;
  logic [IDX_W-1:0] init_bottom, init_right;
  msr_pkg::heading_t heading, heading_next;

  logic [31:0] rd_data;

  always_comb begin
    rows_new = num_rows;
    cols_new = num_cols;
    if (cfg_wr && cfg_sel == msr_pkg::REG_NUM_ROWS) begin
      rows_new = cfg_wdata[msr_pkg::CFG_W-1:0];
    end
    if (cfg_wr && cfg_sel == msr_pkg::REG_NUM_COLS) begin
      cols_new = cfg_wdata[msr_pkg::CFG_W-1:0];
    end
    if (rows_new == '0) begin
      rows_eff = DIM_W'(1);
    end else if (int'(rows_new) > MAX_DIM) begin
      rows_eff = DIM_W'(MAX_DIM);
    end else begin
      rows_eff = DIM_W'(rows_new);
    end
    if (cols_new == '0) begin
      cols_eff = DIM_W'(1);
    end else if (int'(cols_new) > MAX_DIM) begin
      cols_eff = DIM_W'(MAX_DIM);
    end else begin
      cols_eff = DIM_W'(cols_new);
    end
    total       = CNT_W'(rows_eff) * CNT_W'(cols_eff);
    init_bottom = IDX_W'(rows_eff - DIM_W'(1));
    init_right  = IDX_W'(cols_eff - DIM_W'(1));
  end

  assign cfg_rdata = (cfg_sel == msr_pkg::REG_NUM_COLS) ?
                     {{(msr_pkg::DATA_W - msr_pkg::CFG_W){1'b0}}, num_cols} :
                     {{(msr_pkg::DATA_W - msr_pkg::CFG_W){1'b0}}, num_rows};

  // load position, row-major
  always_comb begin
    load_restart = (load_count == '0) || (load_count >= total);
    base_row     = load_restart ? '0 : load_row;
    base_col     = load_restart ? '0 : load_col;
    if (base_col == init_right) begin
      load_col_next = '0;
      load_row_next = base_row + 1'b1;
    end else begin
      load_col_next = base_col + 1'b1;
      load_row_next = base_row;
    end
  end

  assign emitted_inc   = emitted_count + 1'b1;
  assign fetch_last    = (emitted_inc == total);
  assign stat.walk_end = (emitted_count >= total);

  // one step of the clockwise walk
  always_comb begin
    row_next     = cur_row;
    col_next     = cur_col;
    top_next     = bound_top;
    bottom_next  = bound_bottom;
    left_next    = bound_left;
    right_next   = bound_right;
    heading_next = heading;
    unique case (heading)
      msr_pkg::HEAD_RIGHT: begin
        if (cur_col < bound_right) begin
          col_next = cur_col + 1'b1;
        end else begin
          top_next     = bound_top + 1'b1;
          heading_next = msr_pkg::HEAD_DOWN;
          row_next     = cur_row + 1'b1;
        end
      end
      msr_pkg::HEAD_DOWN: begin
        if (cur_row < bound_bottom) begin
          row_next = cur_row + 1'b1;
        end else begin
          right_next   = bound_right - 1'b1;
          heading_next = msr_pkg::HEAD_LEFT;
          col_next     = cur_col - 1'b1;
        end
      end
      msr_pkg::HEAD_LEFT: begin
        if (cur_col > bound_left) begin
          col_next = cur_col - 1'b1;
        end else begin
          bottom_next  = bound_bottom - 1'b1;
          heading_next = msr_pkg::HEAD_UP;
          row_next     = cur_row - 1'b1;
        end
      end
      msr_pkg::HEAD_UP: begin
        if (cur_row > bound_top) begin
          row_next = cur_row - 1'b1;
        end else begin
          left_next    = bound_left + 1'b1;
          heading_next = msr_pkg::HEAD_RIGHT;
          col_next     = cur_col + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows      <= msr_pkg::CFG_W'(1);
      num_cols      <= msr_pkg::CFG_W'(1);
      load_count    <= '0;
      load_row      <= '0;
      load_col      <= '0;
      emitted_count <= '0;
      cur_row       <= '0;
      cur_col       <= '0;
      heading       <= msr_pkg::HEAD_RIGHT;
      bound_top     <= '0;
      bound_left    <= '0;
      bound_bottom  <= '0;
      bound_right   <= '0;
    end else if (cfg_wr) begin
      num_rows      <= rows_new;
      num_cols      <= cols_new;
      load_count    <= '0;
      load_row      <= '0;
      load_col      <= '0;
      emitted_count <= '0;
      cur_row       <= '0;
      cur_col       <= '0;
      heading       <= msr_pkg::HEAD_RIGHT;
      bound_top     <= '0;
      bound_left    <= '0;
      bound_bottom  <= init_bottom;
      bound_right   <= init_right;
    end else if (cmd.load) begin
      load_count <= (load_restart ? CNT_W'(0) : load_count) + 1'b1;
      load_row   <= load_row_next;
      load_col   <= load_col_next;
      if (load_restart) begin
        emitted_count <= '0;
        cur_row       <= '0;
        cur_col       <= '0;
        heading       <= msr_pkg::HEAD_RIGHT;
        bound_top     <= '0;
        bound_left    <= '0;
        bound_bottom  <= init_bottom;
        bound_right   <= init_right;
      end
    end else if (cmd.fetch) begin
      emitted_count <= emitted_inc;
      if (!fetch_last) begin
        cur_row      <= row_next;
        cur_col      <= col_next;
        heading      <= heading_next;
        bound_top    <= top_next;
        bound_bottom <= bottom_next;
        bound_left   <= left_next;
        bound_right  <= right_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rsp.is_last   <= fetch_last;
      rsp.walk_done <= 1'b0;
    end else if (cmd.done_res) begin
      rsp.out_value <= '0;
      rsp.is_last   <= 1'b0;
      rsp.walk_done <= 1'b1;
    end
    if (cmd.capture) begin
      rsp.out_value <= rd_data;
    end
  end

  msr_ram #(
    .WIDTH (32),
    .DEPTH (2 ** ADDR_W)
  ) u_cells (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr ({base_row, base_col}),
    .wr_data (elem_value),
    .rd_en   (cmd.fetch),
    .rd_addr ({cur_row, cur_col}),
    .rd_data (rd_data)
  );

endmodule

@@ src/matrix_spiral_order_reader.sv @@
// Spiral-order matrix reader, top level.
// Load beats (func 0) write a num_rows x num_cols matrix in row-major order, one
// element per beat; a load while nothing is loaded or after a full matrix starts a
// new one. Fetch beats (func 1) return the elements in clockwise spiral order from
// the top-left cell; each result beat passes the registered cell-store read and then
// the output register, and no new beat is taken while a fetch is still reading the
// cell store. A fetch after the walk has ended answers in the next cycle with walk_done
// set. A fetch is held off while an earlier result beat is still stalled; loads are not.
// Cell store is a RAM of MAX_DIM x MAX_DIM words (each index rounded up to a power of
// two); it needs no clearing pass and cells not yet loaded read back undefined.
// Writing num_rows or num_cols restarts loading and the walk.
module matrix_spiral_order_reader #(
  parameter int MAX_DIM = msr_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msr_pkg::PADDR_W-1:0]  paddr,
  input  logic [msr_pkg::DATA_W-1:0]   pwdata,
  output logic [msr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  msr_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output msr_pkg::rsp_t                rsp
);

  msr_pkg::cmd_t  cmd;
  msr_pkg::stat_t stat;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  msr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  msr_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_sel    (paddr[2]),
    .cfg_wdata  (pwdata),
    .cfg_rdata  (prdata),
    .elem_value (req.elem_value),
    .cmd        (cmd),
    .stat       (stat),
    .rsp        (rsp)
  );

endmodule

@@ src/msr_checker.sv @@
// Port-level checks of the spiral-order matrix reader, bound to the top level.
module msr_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input msr_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input msr_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_last && rsp.walk_done))
    else $error("is_last and walk_done both set");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.walk_done |-> rsp.out_value == '0)
    else $error("walk_done beat carries a value");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !req.func && !rsp_valid |=> !rsp_valid)
    else $error("load beat produced a result");

endmodule

bind matrix_spiral_order_reader msr_checker u_msr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
